### rtl/omis_pkg.sv
`timescale 1ns / 1ps
// omis_pkg: shared codes, widths and types of the ordered multi-index stepper
// no dependencies

package omis_pkg;

  // width of one axis number in the walk order register
  localparam int unsigned OrdFieldBits = 2;
  // axis numbers are carried one bit wider so an out-of-range field can be seen
  localparam int unsigned AxisNumBits  = 3;
  // register index on the configuration port
  localparam int unsigned CfgAddrBits  = 3;

  // item kind on the input tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_END       = 2'd1;
  localparam status_t ST_OUTSIDE   = 2'd2;
  localparam status_t ST_BAD_ORDER = 2'd3;

  // sequencer to top: finished result
  typedef struct packed {
    logic    done;
    status_t status;
    logic    active;
  } res_t;

endpackage

### rtl/ordered_multi_index_stepper.sv
`timescale 1ns / 1ps
// ordered_multi_index_stepper: mixed-radix odometer with a run-time axis order
// a load checks the axes in S_LOAD; a step walks the axes in walk order in S_STEP to the
// first one incremented, a bad field or the end; a new word is taken only in idle, after
//   S_DONE, paced by the single shared compare unit, which looks at one axis per cycle
// reset (rst_n low, synchronous): cursor zero, iterator inactive, maxima zero,
//   walk order identity (axis k visited k-th), no result pending
// depends on omis_pkg, omis_ctrl, omis_cmp_unit

module ordered_multi_index_stepper #(
  parameter int unsigned AXES       = 4,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((AXES*COORD_BITS+7)/8)*8-1:0] in_tdata,  // start0, start1, ... from bit 0
  input  logic                              in_tuser,   // mode
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((AXES*COORD_BITS+7)/8)*8-1:0] out_tdata, // coord0, coord1, ... from bit 0
  output logic [2:0]                        out_tuser,  // status [1:0], active [2]
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [omis_pkg::CfgAddrBits-1:0]  cfg_addr,
  input  logic [((COORD_BITS > 2*AXES) ? COORD_BITS : 2*AXES)-1:0] cfg_data
);

  localparam int unsigned TdW  = ((AXES*COORD_BITS+7)/8)*8;
  localparam int unsigned CrdW = AXES*COORD_BITS;
  localparam int unsigned OrdW = AXES*omis_pkg::OrdFieldBits;
  localparam int unsigned AxW  = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned CaW  = omis_pkg::CfgAddrBits;

  // identity order: field k holds axis k
  function automatic logic [OrdW-1:0] ord_reset();
    logic [OrdW-1:0] r;
    r = '0;
    for (int k = 0; k < AXES; k++) begin
      r[k*omis_pkg::OrdFieldBits +: omis_pkg::OrdFieldBits] = k[omis_pkg::OrdFieldBits-1:0];
    end
    return r;
  endfunction

  logic [CrdW-1:0]       axis_max_r;
  logic [OrdW-1:0]       walk_order_r;
  logic                  out_valid_r;
  logic [CrdW-1:0]       out_coords_r;
  omis_pkg::status_t     out_status_r;
  logic                  out_active_r;

  logic                  go;
  logic                  out_free;
  omis_pkg::res_t        res;
  logic [CrdW-1:0]       coords;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_max_r   <= '0;
      walk_order_r <= ord_reset();
    end else if (cfg_valid) begin
      if (cfg_addr < CaW'(AXES)) begin
        axis_max_r[cfg_addr[AxW-1:0]*COORD_BITS +: COORD_BITS] <= cfg_data[COORD_BITS-1:0];
      end else if (cfg_addr == CaW'(AXES)) begin
        walk_order_r <= cfg_data[OrdW-1:0];
      end
    end
  end

  assign go       = in_tvalid & in_tready;
  // result register can take a new word when empty or being drained
  assign out_free = !out_valid_r || out_tready;

  omis_ctrl #(
    .AXES      (AXES),
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .mode      (in_tuser),
    .start     (in_tdata[CrdW-1:0]),
    .axis_max  (axis_max_r),
    .walk_order(walk_order_r),
    .out_free  (out_free),
    .ready     (in_tready),
    .res       (res),
    .coords    (coords)
  );

  // output register decouples the sequencer from the result consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done && out_free) begin
      out_coords_r <= coords;
      out_status_r <= res.status;
      out_active_r <= res.active;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TdW'(out_coords_r);
  assign out_tuser  = {out_active_r, out_status_r};

endmodule

### rtl/omis_cmp_unit.sv
`timescale 1ns / 1ps
// omis_cmp_unit: the shared compare and increment unit
// no dependencies; used by omis_ctrl for both the load check and the step walk

module omis_cmp_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0] a,
  input  logic [COORD_BITS-1:0] b,
  output logic                  eq,
  output logic                  gt,
  output logic [COORD_BITS-1:0] inc
);

  assign eq  = (a == b);
  assign gt  = (a > b);
  assign inc = a + COORD_BITS'(1);

endmodule

### rtl/omis_ctrl.sv
`timescale 1ns / 1ps
// omis_ctrl: sequencer, cursor and running flag, one axis per cycle
// depends on omis_pkg and omis_cmp_unit

module omis_ctrl #(
  parameter int unsigned AXES       = 4,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic                              mode,
  input  logic [AXES*COORD_BITS-1:0]        start,
  input  logic [AXES*COORD_BITS-1:0]        axis_max,
  input  logic [AXES*omis_pkg::OrdFieldBits-1:0] walk_order,
  input  logic                              out_free,
  output logic                              ready,
  output omis_pkg::res_t                    res,
  output logic [AXES*COORD_BITS-1:0]        coords
);

  localparam int unsigned AxW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned OFB = omis_pkg::OrdFieldBits;
  localparam int unsigned ANW = omis_pkg::AxisNumBits;
  localparam logic [AxW-1:0] KLast = AxW'(AXES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [AxW-1:0]              k_r, k_nxt;
  logic [AXES*COORD_BITS-1:0]  start_r, start_nxt;
  logic [COORD_BITS-1:0]       cursor_r [AXES];
  logic [COORD_BITS-1:0]       cursor_nxt [AXES];
  logic                        running_r, running_nxt;
  omis_pkg::status_t           status_r, status_nxt;

  logic [ANW-1:0]              ax_num;
  logic                        ax_ok;
  logic [AxW-1:0]              ax_idx;
  logic                        perm_ok;
  logic [COORD_BITS-1:0]       op_a, op_b, op_inc;
  logic                        op_eq, op_gt;

  // axis visited at walk position k
  assign ax_num = ANW'(walk_order[k_r*OFB +: OFB]);
  assign ax_ok  = (ax_num < ANW'(AXES));
  assign ax_idx = ax_num[AxW-1:0];

  // every axis number must appear among the walk fields
  always_comb begin
    logic found;
    perm_ok = 1'b1;
    for (int n = 0; n < AXES; n++) begin
      found = 1'b0;
      for (int f = 0; f < AXES; f++) begin
        if (ANW'(walk_order[f*OFB +: OFB]) == ANW'(n)) begin
          found = 1'b1;
        end
      end
      perm_ok = perm_ok & found;
    end
  end

  // operand select for the shared unit
  always_comb begin
    if (state_r == S_LOAD) begin
      op_a = start_r[k_r*COORD_BITS +: COORD_BITS];
      op_b = axis_max[k_r*COORD_BITS +: COORD_BITS];
    end else begin
      op_a = ax_ok ? cursor_r[ax_idx] : '0;
      op_b = ax_ok ? axis_max[ax_idx*COORD_BITS +: COORD_BITS] : '0;
    end
  end

  omis_cmp_unit #(.COORD_BITS(COORD_BITS)) u_cmp (
    .a  (op_a),
    .b  (op_b),
    .eq (op_eq),
    .gt (op_gt),
    .inc(op_inc)
  );

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    start_nxt   = start_r;
    cursor_nxt  = cursor_r;
    running_nxt = running_r;
    status_nxt  = status_r;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          k_nxt = '0;
          if (mode == omis_pkg::MODE_LOAD) begin
            start_nxt = start;
            state_nxt = S_LOAD;
          end else if (!running_r) begin
            status_nxt = omis_pkg::ST_END;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_LOAD: begin
        if (op_gt) begin
          status_nxt  = omis_pkg::ST_OUTSIDE;
          running_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else if (k_r == KLast) begin
          if (!perm_ok) begin
            status_nxt  = omis_pkg::ST_BAD_ORDER;
            running_nxt = 1'b0;
          end else begin
            for (int a = 0; a < AXES; a++) begin
              cursor_nxt[a] = start_r[a*COORD_BITS +: COORD_BITS];
            end
            status_nxt  = omis_pkg::ST_OK;
            running_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + AxW'(1);
        end
      end
      S_STEP: begin
        if (!ax_ok) begin
          // bad field: earlier wraps stay, running untouched
          status_nxt = omis_pkg::ST_BAD_ORDER;
          state_nxt  = S_DONE;
        end else if (op_eq) begin
          cursor_nxt[ax_idx] = '0;
          if (k_r == KLast) begin
            status_nxt  = omis_pkg::ST_END;
            running_nxt = 1'b0;
            state_nxt   = S_DONE;
          end else begin
            k_nxt = k_r + AxW'(1);
          end
        end else if (op_gt) begin
          // maximum lowered under the cursor
          status_nxt  = omis_pkg::ST_END;
          running_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else begin
          cursor_nxt[ax_idx] = op_inc;
          status_nxt         = omis_pkg::ST_OK;
          state_nxt          = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= '0;
      running_r <= 1'b0;
      status_r  <= omis_pkg::ST_OK;
      for (int a = 0; a < AXES; a++) begin
        cursor_r[a] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      running_r <= running_nxt;
      status_r  <= status_nxt;
      cursor_r  <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
  end

  assign ready      = (state_r == S_IDLE);
  assign res.done   = (state_r == S_DONE);
  assign res.status = status_r;
  assign res.active = running_r;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      coords[a*COORD_BITS +: COORD_BITS] = cursor_r[a];
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking regression of ordered_multi_index_stepper, with an in-bench
// odometer predictor, directed corner cases, then random load/step walks under idling
// depends on omis_pkg and ordered_multi_index_stepper

module testbench;
  import omis_pkg::*;

  localparam int unsigned AXES       = 4;
  localparam int unsigned COORD_BITS = 16;

  // configuration register indexes
  localparam logic [CfgAddrBits-1:0] REG_AXIS0_MAX  = 3'd0;
  localparam logic [CfgAddrBits-1:0] REG_AXIS1_MAX  = 3'd1;
  localparam logic [CfgAddrBits-1:0] REG_AXIS2_MAX  = 3'd2;
  localparam logic [CfgAddrBits-1:0] REG_AXIS3_MAX  = 3'd3;
  localparam logic [CfgAddrBits-1:0] REG_WALK_ORDER = 3'd4;

  // walk orders: axis 0 fastest, axis 3 fastest, and all fields naming one axis
  localparam logic [7:0] ORDER_IDENTITY = 8'hE4;
  localparam logic [7:0] ORDER_REVERSED = 8'h1B;
  localparam logic [7:0] ORDER_ALL_ZERO = 8'h00;
  // fields 1,1,0,0 from the lowest up: a duplicated axis
  localparam logic [7:0] ORDER_DUP      = 8'h05;

  localparam logic [15:0] COORD_TOP = 16'hFFFF;

  typedef logic [AXES-1:0][COORD_BITS-1:0] coords_t;

  typedef struct {
    coords_t coords;
    status_t status;
    logic    active;
  } odo_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // start0, start1, start2, start3 from bit 0
  logic        in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // coord0, coord1, coord2, coord3 from bit 0
  logic [2:0]  out_tuser;  // status [1:0], active [2]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CfgAddrBits-1:0] cfg_addr;
  logic [15:0] cfg_data;

  ordered_multi_index_stepper #(
    .AXES       (AXES),
    .COORD_BITS (COORD_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // predictor state: limits, walk order, cursor and running flag
  logic [COORD_BITS-1:0] ax_limit [AXES];
  logic [7:0]            visit_order;
  coords_t               odo_pos;
  logic                  odo_live;

  odo_result_t coords_due [$];

  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  int n_loads;
  int n_steps;
  int n_cfg_writes;
  int n_checked;
  int n_status [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected result of one accepted word, advancing the predictor state
  function automatic odo_result_t advance_odometer(input logic mode, input coords_t start);
    odo_result_t res;
    logic        fits;
    logic        is_perm;
    logic        found;
    logic        done;
    logic [1:0]  ax;
    int          a;
    int          k;
    fits    = 1'b1;
    is_perm = 1'b1;
    res.status = ST_OK;
    if (mode == MODE_LOAD) begin
      for (a = 0; a < AXES; a++)
        if (start[a] > ax_limit[a]) fits = 1'b0;
      for (a = 0; a < AXES; a++) begin
        found = 1'b0;
        for (k = 0; k < AXES; k++)
          if (visit_order[2*k +: 2] == a[1:0]) found = 1'b1;
        if (!found) is_perm = 1'b0;
      end
      // grid check wins over the order check; a rejected load keeps the cursor
      if (!fits) begin
        odo_live   = 1'b0;
        res.status = ST_OUTSIDE;
      end else if (!is_perm) begin
        odo_live   = 1'b0;
        res.status = ST_BAD_ORDER;
      end else begin
        odo_pos  = start;
        odo_live = 1'b1;
      end
      n_loads++;
    end else begin
      n_steps++;
      if (!odo_live) begin
        res.status = ST_END;
      end else begin
        // 2-bit fields cannot name an axis beyond the fourth, so no bad order here
        done       = 1'b0;
        res.status = ST_END;
        for (k = 0; k < AXES; k++) begin
          if (!done) begin
            ax = visit_order[2*k +: 2];
            if (odo_pos[ax] == ax_limit[ax]) begin
              odo_pos[ax] = '0;
            end else if (odo_pos[ax] > ax_limit[ax]) begin
              // limit lowered under the cursor: earlier wraps stand
              done = 1'b1;
            end else begin
              odo_pos[ax] = odo_pos[ax] + 1'b1;
              res.status  = ST_OK;
              done        = 1'b1;
            end
          end
        end
        if (res.status == ST_END) odo_live = 1'b0;
      end
    end
    res.coords = odo_pos;
    res.active = odo_live;
    n_status[res.status]++;
    return res;
  endfunction

  // result checker: every accepted result word against the oldest expectation
  always @(posedge clk) begin
    odo_result_t want;
    coords_t     got;
    int          a;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (coords_due.size() == 0) begin
        $error("result word with nothing expected: coords %h, tuser %b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = coords_due.pop_front();
        n_checked++;
        for (a = 0; a < AXES; a++)
          if (got[a] !== want.coords[a]) begin
            $error("coord%0d mismatch: expected %0d, got %0d", a, want.coords[a], got[a]);
            fail_count++;
          end
        if (out_tuser[1:0] !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_tuser[1:0]);
          fail_count++;
        end
        if (out_tuser[2] !== want.active) begin
          $error("active mismatch: expected %0d, got %0d", want.active, out_tuser[2]);
          fail_count++;
        end
      end
    end
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk)
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // one input word; leaves tvalid high, the next send or wait_idle takes it over
  task automatic send_word(input logic mode, input coords_t data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = data;
    do @(posedge clk); while (!in_tready);
    coords_due.push_back(advance_odometer(mode, data));
    @(negedge clk);
  endtask

  // lets every pending result come out, then the pipeline settle
  task automatic wait_idle();
    int guard;
    in_tvalid = 1'b0;
    guard     = 0;
    while (coords_due.size() != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    if (coords_due.size() != 0) begin
      $error("%0d result words never arrived", coords_due.size());
      fail_count++;
      coords_due.delete();
    end
    repeat (AXES + 4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrBits-1:0] addr, input logic [15:0] value);
    in_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_addr  = addr;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (addr == REG_WALK_ORDER)
      visit_order = value[7:0];
    else if (addr < AXES)
      ax_limit[addr[1:0]] = value;
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] m0, input logic [15:0] m1,
                            input logic [15:0] m2, input logic [15:0] m3);
    write_reg(REG_AXIS0_MAX, m0);
    write_reg(REG_AXIS1_MAX, m1);
    write_reg(REG_AXIS2_MAX, m2);
    write_reg(REG_AXIS3_MAX, m3);
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return COORD_TOP;
      1:       return 16'($urandom);
      2:       return 16'd0;
      default: return 16'($urandom_range(0, 3));
    endcase
  endfunction

  // mostly a shuffled permutation, now and then any byte
  function automatic logic [7:0] pick_order();
    logic [1:0] f [4];
    logic [1:0] t;
    int         j;
    int         k;
    if ($urandom_range(0, 99) < 12) return 8'($urandom);
    for (k = 0; k < 4; k++) f[k] = 2'(k);
    for (k = 3; k > 0; k--) begin
      j    = $urandom_range(0, k);
      t    = f[k];
      f[k] = f[j];
      f[j] = t;
    end
    return {f[3], f[2], f[1], f[0]};
  endfunction

  // start index: at the limit, inside the grid, or any value at all
  function automatic coords_t pick_start();
    coords_t s;
    int      a;
    int      r;
    for (a = 0; a < AXES; a++) begin
      r = $urandom_range(0, 99);
      if (r < 15)
        s[a] = ax_limit[a];
      else if (r < 88)
        s[a] = 16'($urandom_range(0, ax_limit[a]));
      else
        s[a] = 16'($urandom);
    end
    return s;
  endfunction

  // inactive after reset, load of the origin with zero limits, wrap of a one-point grid
  task automatic test_after_reset();
    send_word(MODE_STEP, '0);
    send_word(MODE_LOAD, '0);
    send_word(MODE_STEP, {4{COORD_TOP}});
    send_word(MODE_STEP, '0);
    wait_idle();
  endtask

  // grid check, order check and their precedence
  task automatic test_load_checks();
    set_limits(16'd3, 16'd0, COORD_TOP, 16'd1);
    send_word(MODE_LOAD, {16'd1, COORD_TOP, 16'd0, 16'd4});
    wait_idle();
    write_reg(REG_WALK_ORDER, ORDER_ALL_ZERO);
    send_word(MODE_LOAD, {16'd1, COORD_TOP, 16'd0, 16'd3});
    send_word(MODE_LOAD, {16'd1, COORD_TOP, 16'd0, 16'd4});
    wait_idle();
    write_reg(REG_WALK_ORDER, ORDER_IDENTITY);
    send_word(MODE_LOAD, {16'd1, COORD_TOP, 16'd0, 16'd3});
    send_word(MODE_STEP, '0);
    wait_idle();
  endtask

  // carries through several axes, incrementing up to the top code
  task automatic test_carry_chain();
    send_word(MODE_LOAD, {16'd0, 16'hFFFE, 16'd0, 16'd2});
    send_word(MODE_STEP, '0);
    send_word(MODE_STEP, '0);
    send_word(MODE_STEP, '0);
    wait_idle();
    set_limits(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
    send_word(MODE_LOAD, {4{COORD_TOP}});
    send_word(MODE_STEP, '0);
    wait_idle();
  endtask

  // reversed order, then a duplicated axis written while active
  task automatic test_order_change();
    set_limits(16'd1, 16'd1, 16'd1, 16'd1);
    write_reg(REG_WALK_ORDER, ORDER_REVERSED);
    send_word(MODE_LOAD, {16'd1, 16'd0, 16'd0, 16'd0});
    send_word(MODE_STEP, '0);
    wait_idle();
    write_reg(REG_WALK_ORDER, ORDER_DUP);
    send_word(MODE_STEP, '0);
    send_word(MODE_STEP, '0);
    wait_idle();
    write_reg(REG_WALK_ORDER, ORDER_IDENTITY);
  endtask

  // limit lowered below the cursor after the load: wrapped axes stay at zero
  task automatic test_lowered_limit();
    set_limits(16'd5, 16'd200, 16'd0, 16'd0);
    send_word(MODE_LOAD, {16'd0, 16'd0, 16'd100, 16'd5});
    wait_idle();
    write_reg(REG_AXIS1_MAX, 16'd10);
    send_word(MODE_STEP, '0);
    send_word(MODE_STEP, '0);
    wait_idle();
  endtask

  // random walks in four idling phases
  task automatic test_random_walks();
    int phase;
    int budget;
    int a;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(78, 0);
        2:       set_idling(0, 78);
        default: set_idling(29, 29);
      endcase
      budget = 320;
      while (budget > 0) begin
        wait_idle();
        for (a = 0; a < AXES; a++)
          write_reg(REG_AXIS0_MAX + 3'(a), pick_limit());
        write_reg(REG_WALK_ORDER, pick_order());
        send_word(MODE_LOAD, pick_start());
        budget--;
        repeat ($urandom_range(1, 40)) begin
          case ($urandom_range(0, 49))
            0: begin
              // move one limit in the middle of a walk
              wait_idle();
              write_reg(REG_AXIS0_MAX + 3'($urandom_range(0, AXES - 1)), pick_limit());
            end
            1: begin
              // any order byte, duplicates included, while active
              wait_idle();
              write_reg(REG_WALK_ORDER, 8'($urandom));
            end
            2: begin
              send_word(MODE_LOAD, pick_start());
              budget--;
            end
            default: ;
          endcase
          send_word(MODE_STEP, {$urandom, $urandom});
          budget--;
        end
      end
    end
  endtask

  initial begin
    int a;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = MODE_LOAD;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_addr     = '0;
    cfg_data     = '0;
    fail_count   = 0;
    n_loads      = 0;
    n_steps      = 0;
    n_cfg_writes = 0;
    n_checked    = 0;
    for (a = 0; a < 4; a++) n_status[a] = 0;
    for (a = 0; a < AXES; a++) ax_limit[a] = '0;
    visit_order = ORDER_IDENTITY;
    odo_pos     = '0;
    odo_live    = 1'b0;
    set_idling(0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_load_checks();
    test_carry_chain();
    test_order_change();
    test_lowered_limit();
    test_random_walks();
    wait_idle();

    $display("%0d words checked: %0d loads, %0d steps, %0d register writes, four idling phases",
             n_checked, n_loads, n_steps, n_cfg_writes);
    $display("status mix: ok %0d, end %0d, outside grid %0d, bad order %0d",
             n_status[ST_OK], n_status[ST_END], n_status[ST_OUTSIDE], n_status[ST_BAD_ORDER]);
    if (fail_count == 0) begin
      $display("ordered_multi_index_stepper regression: pass");
    end else begin
      $display("ordered_multi_index_stepper regression: fail");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #(5_000_000);
    $display("ordered_multi_index_stepper regression: fail");
    $finish;
  end

endmodule

### files.f
rtl/omis_pkg.sv
rtl/omis_cmp_unit.sv
rtl/omis_ctrl.sv
rtl/ordered_multi_index_stepper.sv
sim/testbench.sv
